/* hdl/qyt_pkg.sv */
// Shared constants, transition codes and inter-module types of the yaw tracker.
package qyt_pkg;

    // Field widths
    localparam int DEG_W      = 10;
    localparam int CNT_W      = 11;
    localparam int UP_W       = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Products count*scale and limit*divisor, sized for scale and divisor up to 4096
    localparam int PROD_W = 25;
    localparam int MAG_W  = 24;

    // Parameter defaults
    localparam int SCALE_DEF   = 360;
    localparam int DIVISOR_DEF = 448;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd1;

    // Register reset values
    localparam logic [UP_W-1:0]         UPPER_RST = 9'd179;
    localparam logic signed [DEG_W-1:0] LOWER_RST = -10'sd180;

    // Input item kinds
    localparam logic MODE_PHASE = 1'b0;
    localparam logic MODE_REF   = 1'b1;

    // Cycles the limit datapath needs after reset or a limit write
    localparam int                SETTLE_W    = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_LOAD = 2'd3;

    // Transition codes {previous A B, new A B}
    localparam logic [3:0] QC_FWD_00_01 = 4'b0001;
    localparam logic [3:0] QC_FWD_01_11 = 4'b0111;
    localparam logic [3:0] QC_FWD_11_10 = 4'b1110;
    localparam logic [3:0] QC_FWD_10_00 = 4'b1000;
    localparam logic [3:0] QC_REV_00_10 = 4'b0010;
    localparam logic [3:0] QC_REV_01_00 = 4'b0100;
    localparam logic [3:0] QC_REV_11_01 = 4'b1101;
    localparam logic [3:0] QC_REV_10_11 = 4'b1011;

    // Wrap thresholds and set-back counts derived from the limit registers
    typedef struct packed {
        logic signed [PROD_W-1:0] thr_hi;
        logic signed [PROD_W-1:0] thr_lo;
        logic [CNT_W-1:0]         back_up;
        logic [CNT_W-1:0]         back_lo;
        logic signed [DEG_W-1:0]  up_deg;
        logic signed [DEG_W-1:0]  lo_deg;
        logic                     settled;
    } t_limits;

    // One item after the count update, on its way to the angle divider
    typedef struct packed {
        logic [MAG_W-1:0]        mag;
        logic                    neg;
        logic                    wrap;
        logic signed [DEG_W-1:0] lim_deg;
        logic [CNT_W-1:0]        count;
        logic                    found;
    } t_track;

    // Treat a zero scale or divisor as one
    function automatic int eff(input int v);
        return (v == 0) ? 1 : v;
    endfunction

endpackage

/* hdl/qyt_in_if.sv */
// Input channel: phase sample or reference pulse with valid/ready.
interface qyt_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [1:0] phases;

    modport source (output valid, output mode, output phases, input ready);
    modport sink   (input valid, input mode, input phases, output ready);
endinterface

/* hdl/qyt_out_if.sv */
// Output channel: yaw angle, count and flags with valid/ready.
interface qyt_out_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] yaw_degrees;
    logic signed [10:0] slot_total;
    logic              reference_found;
    logic              wrapped;

    modport source (output valid, output yaw_degrees, output slot_total,
                    output reference_found, output wrapped, input ready);
    modport sink   (input valid, input yaw_degrees, input slot_total,
                    input reference_found, input wrapped, output ready);
endinterface

/* hdl/qyt_limits.sv */
// Limit registers and the short pipeline that turns them into thresholds and set-back counts.
module qyt_limits import qyt_pkg::*; #(
    parameter int COUNT_SCALE   = SCALE_DEF,
    parameter int COUNT_DIVISOR = DIVISOR_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_limits               o_lim
);
    localparam int S_EFF = eff(COUNT_SCALE);
    localparam int D_EFF = eff(COUNT_DIVISOR);
    localparam logic signed [PROD_W-1:0] DIV_S = PROD_W'(D_EFF);

    // Reciprocal of the scale, exact for every |limit*divisor| in range
    localparam int BACK_N  = $clog2((2 ** (DEG_W - 1)) * D_EFF + 1);
    localparam int BACK_K  = BACK_N + $clog2(S_EFF);
    localparam int RB_W    = BACK_K + 1;
    localparam int RB_LO_W = (RB_W + 1) / 2;
    localparam int RB_HI_W = RB_W - RB_LO_W;
    localparam logic [RB_W-1:0] RECIP_B =
        RB_W'(((64'd1 << BACK_K) + 64'(S_EFF) - 64'd1) / 64'(S_EFF));
    localparam logic [RB_LO_W-1:0] RECIP_B_LO = RECIP_B[RB_LO_W-1:0];
    localparam logic [RB_HI_W-1:0] RECIP_B_HI = RECIP_B[RB_W-1:RB_LO_W];
    localparam int SUM_W = MAG_W + RB_W;

    logic [UP_W-1:0]            r_upper;
    logic signed [DEG_W-1:0]    r_lower;
    logic [SETTLE_W-1:0]        r_settle;
    logic signed [PROD_W-1:0]   r_up_prod;
    logic signed [PROD_W-1:0]   r_lo_prod;
    logic signed [PROD_W-1:0]   r_thr_hi;
    logic signed [PROD_W-1:0]   r_thr_lo;
    logic [MAG_W+RB_LO_W-1:0]   r_up_pp_lo;
    logic [MAG_W+RB_HI_W-1:0]   r_up_pp_hi;
    logic [MAG_W+RB_LO_W-1:0]   r_lo_pp_lo;
    logic [MAG_W+RB_HI_W-1:0]   r_lo_pp_hi;
    logic                       r_lo_neg;
    logic [CNT_W-1:0]           r_back_up;
    logic [CNT_W-1:0]           r_back_lo;

    logic [MAG_W-1:0]           up_mag;
    logic [MAG_W-1:0]           lo_mag;
    logic signed [PROD_W-1:0]   n_thr_hi;
    logic signed [PROD_W-1:0]   n_thr_lo;
    logic [SUM_W-1:0]           up_sum;
    logic [SUM_W-1:0]           lo_sum;
    logic [CNT_W-1:0]           up_q;
    logic [CNT_W-1:0]           lo_q;
    logic [SETTLE_W-1:0]        n_settle;

    // Take limit writes; restart the settle count on any write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper  <= UPPER_RST;
            r_lower  <= LOWER_RST;
            r_settle <= SETTLE_LOAD;
        end else begin
            r_settle <= n_settle;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_UPPER: r_upper <= i_cfg_data[UP_W-1:0];
                    REG_LOWER: r_lower <= $signed(i_cfg_data[DEG_W-1:0]);
                endcase
            end
        end
    end

    always_comb begin
        if (i_cfg_we) begin
            n_settle = SETTLE_LOAD;
        end else if (r_settle != '0) begin
            n_settle = r_settle - SETTLE_W'(1);
        end else begin
            n_settle = r_settle;
        end
    end

    // Thresholds: angle >= upper is prod >= upper*D, angle <= lower is prod <= lower*D,
    // adjusted where truncation toward zero shifts the boundary around zero
    always_comb begin
        up_mag   = MAG_W'(r_up_prod);
        lo_mag   = r_lo_prod[PROD_W-1] ? MAG_W'(-r_lo_prod) : MAG_W'(r_lo_prod);
        n_thr_hi = (r_up_prod == '0) ? -(DIV_S - PROD_W'(1)) : r_up_prod;
        n_thr_lo = r_lo_prod[PROD_W-1] ? r_lo_prod : r_lo_prod + DIV_S - PROD_W'(1);
    end

    // Stage A: limit times divisor; stage B: partial products by the reciprocal
    always_ff @(posedge i_clk) begin
        r_up_prod  <= PROD_W'($signed({1'b0, r_upper})) * DIV_S;
        r_lo_prod  <= PROD_W'(r_lower) * DIV_S;
        r_thr_hi   <= n_thr_hi;
        r_thr_lo   <= n_thr_lo;
        r_up_pp_lo <= (MAG_W+RB_LO_W)'(up_mag) * (MAG_W+RB_LO_W)'(RECIP_B_LO);
        r_up_pp_hi <= (MAG_W+RB_HI_W)'(up_mag) * (MAG_W+RB_HI_W)'(RECIP_B_HI);
        r_lo_pp_lo <= (MAG_W+RB_LO_W)'(lo_mag) * (MAG_W+RB_LO_W)'(RECIP_B_LO);
        r_lo_pp_hi <= (MAG_W+RB_HI_W)'(lo_mag) * (MAG_W+RB_HI_W)'(RECIP_B_HI);
        r_lo_neg   <= r_lo_prod[PROD_W-1];
        r_back_up  <= up_q;
        r_back_lo  <= r_lo_neg ? -lo_q : lo_q;
    end

    // Stage C: sum partial products, keep the quotient bits
    always_comb begin
        up_sum = (SUM_W'(r_up_pp_hi) << RB_LO_W) + SUM_W'(r_up_pp_lo);
        lo_sum = (SUM_W'(r_lo_pp_hi) << RB_LO_W) + SUM_W'(r_lo_pp_lo);
        up_q   = up_sum[BACK_K +: CNT_W];
        lo_q   = lo_sum[BACK_K +: CNT_W];
    end

    always_comb begin
        o_lim.thr_hi  = r_thr_hi;
        o_lim.thr_lo  = r_thr_lo;
        o_lim.back_up = r_back_up;
        o_lim.back_lo = r_back_lo;
        o_lim.up_deg  = $signed({1'b0, r_upper});
        o_lim.lo_deg  = r_lower;
        o_lim.settled = (r_settle == '0);
    end

endmodule

/* hdl/qyt_tracker.sv */
// Phase decoder, count loop: one item per cycle into the first stage unless stalled.
module qyt_tracker import qyt_pkg::*; #(
    parameter int COUNT_SCALE = SCALE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_limits    i_lim,
    input  logic       i_valid,
    input  logic       i_mode,
    input  logic [1:0] i_phases,
    output logic       o_ready,
    input  logic       i_adv,
    output logic       o_s1_valid,
    output t_track     o_s1
);
    localparam int S_EFF = eff(COUNT_SCALE);
    localparam logic signed [PROD_W-1:0] SCALE_S = PROD_W'(S_EFF);

    logic [1:0]               r_prev;
    logic signed [CNT_W-1:0]  r_count;
    logic                     r_found;
    logic                     r_valid;
    t_track                   r_s1;

    logic                     en;
    logic                     take;
    logic [3:0]               code;
    logic [CNT_W-1:0]         delta;
    logic signed [CNT_W-1:0]  c1;
    logic signed [PROD_W-1:0] prod;
    logic                     hit_hi;
    logic                     hit_lo;
    logic [1:0]               n_prev;
    logic [CNT_W-1:0]         n_count;
    logic                     n_found;
    t_track                   n_s1;

    assign en      = !r_valid || i_adv;
    assign o_ready = en && i_lim.settled;
    assign take    = i_valid && o_ready;

    // Decode the transition into a count step
    always_comb begin
        code = {r_prev, i_phases};
        unique case (code)
            QC_FWD_00_01, QC_FWD_01_11, QC_FWD_11_10, QC_FWD_10_00: delta = CNT_W'(1);
            QC_REV_00_10, QC_REV_01_00, QC_REV_11_01, QC_REV_10_11: delta = '1;
            default:                                                delta = '0;
        endcase
    end

    // Step, scale and test against both limits
    always_comb begin
        c1     = r_count + $signed(delta);
        prod   = PROD_W'(c1) * SCALE_S;
        hit_hi = (prod >= i_lim.thr_hi);
        hit_lo = (prod <= i_lim.thr_lo);
    end

    // Next state and the item handed to the divider; upper limit wins
    always_comb begin
        n_prev       = r_prev;
        n_count      = r_count;
        n_found      = r_found;
        n_s1.mag     = prod[PROD_W-1] ? MAG_W'(-prod) : MAG_W'(prod);
        n_s1.neg     = prod[PROD_W-1];
        n_s1.wrap    = 1'b0;
        n_s1.lim_deg = '0;
        if (i_mode == MODE_REF) begin
            n_count  = '0;
            n_found  = 1'b1;
            n_s1.mag = '0;
            n_s1.neg = 1'b0;
        end else begin
            n_prev = i_phases;
            priority if (hit_hi) begin
                n_count      = i_lim.back_lo;
                n_s1.wrap    = 1'b1;
                n_s1.lim_deg = i_lim.lo_deg;
            end else if (hit_lo) begin
                n_count      = i_lim.back_up;
                n_s1.wrap    = 1'b1;
                n_s1.lim_deg = i_lim.up_deg;
            end else begin
                n_count = c1;
            end
        end
        n_s1.count = n_count;
        n_s1.found = n_found;
    end

    // Advance state on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_count <= '0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (take) begin
                r_prev  <= n_prev;
                r_count <= $signed(n_count);
                r_found <= n_found;
            end
            if (en) begin
                r_valid <= take;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_valid;
    assign o_s1       = r_s1;

endmodule

/* hdl/qyt_angle.sv */
// Angle divider: magnitude times reciprocal of the divisor, then sign and result register.
module qyt_angle import qyt_pkg::*; #(
    parameter int COUNT_SCALE   = SCALE_DEF,
    parameter int COUNT_DIVISOR = DIVISOR_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s1_valid,
    input  t_track           i_s1,
    output logic             o_adv,
    qyt_out_if.source        o_out
);
    localparam int S_EFF = eff(COUNT_SCALE);
    localparam int D_EFF = eff(COUNT_DIVISOR);

    // Reciprocal of the divisor, exact for every |count*scale| in range
    localparam int ANG_N   = $clog2((2 ** (CNT_W - 1)) * S_EFF + 1);
    localparam int ANG_K   = ANG_N + $clog2(D_EFF);
    localparam int RA_W    = ANG_K + 1;
    localparam int RA_LO_W = (RA_W + 1) / 2;
    localparam int RA_HI_W = RA_W - RA_LO_W;
    localparam logic [RA_W-1:0] RECIP_A =
        RA_W'(((64'd1 << ANG_K) + 64'(D_EFF) - 64'd1) / 64'(D_EFF));
    localparam logic [RA_LO_W-1:0] RECIP_A_LO = RECIP_A[RA_LO_W-1:0];
    localparam logic [RA_HI_W-1:0] RECIP_A_HI = RECIP_A[RA_W-1:RA_LO_W];
    localparam int SUM_W = MAG_W + RA_W;

    logic                     r_v2;
    logic [MAG_W+RA_LO_W-1:0] r_pp_lo;
    logic [MAG_W+RA_HI_W-1:0] r_pp_hi;
    t_track                   r_t2;
    logic                     r_vo;
    logic signed [DEG_W-1:0]  r_yaw;
    logic [CNT_W-1:0]         r_slot;
    logic                     r_found;
    logic                     r_wrap;

    logic                     en_out;
    logic                     en2;
    logic [SUM_W-1:0]         sum;
    logic [DEG_W-1:0]         q;
    logic signed [DEG_W-1:0]  deg;

    assign en_out = !r_vo || o_out.ready;
    assign en2    = !r_v2 || en_out;
    assign o_adv  = en2;

    // Drop the quotient bits out of the summed partial products; apply sign or limit
    always_comb begin
        sum = (SUM_W'(r_pp_hi) << RA_LO_W) + SUM_W'(r_pp_lo);
        q   = sum[ANG_K +: DEG_W];
        if (r_t2.wrap) begin
            deg = r_t2.lim_deg;
        end else if (r_t2.neg) begin
            deg = $signed(-q);
        end else begin
            deg = $signed(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_s1_valid;
            end
            if (en_out) begin
                r_vo <= r_v2;
            end
        end
    end

    // Partial products stage
    always_ff @(posedge i_clk) begin
        if (en2 && i_s1_valid) begin
            r_pp_lo <= (MAG_W+RA_LO_W)'(i_s1.mag) * (MAG_W+RA_LO_W)'(RECIP_A_LO);
            r_pp_hi <= (MAG_W+RA_HI_W)'(i_s1.mag) * (MAG_W+RA_HI_W)'(RECIP_A_HI);
            r_t2    <= i_s1;
        end
    end

    // Result register; hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (en_out && r_v2) begin
            r_yaw   <= deg;
            r_slot  <= r_t2.count;
            r_found <= r_t2.found;
            r_wrap  <= r_t2.wrap;
        end
    end

    assign o_out.valid           = r_vo;
    assign o_out.yaw_degrees     = r_yaw;
    assign o_out.slot_total      = $signed(r_slot);
    assign o_out.reference_found = r_found;
    assign o_out.wrapped         = r_wrap;

endmodule

/* hdl/quadrature_yaw_tracker_top.sv */
// Top level of the x4 quadrature yaw tracker.
// Pipeline: the tracker's item register, the partial products register, then the result register.
// Throughput: one item per cycle unless the output stalls or the limits settle; each transfer registers the new count.
// Reset: pipeline emptied, count/phases/found cleared, limits to 179 and -180 degrees.
// After reset and after any limit write the input is not ready while the thresholds
// and set-back counts are recomputed.
module quadrature_yaw_tracker_top import qyt_pkg::*; #(
    parameter int COUNT_SCALE   = SCALE_DEF,
    parameter int COUNT_DIVISOR = DIVISOR_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    qyt_in_if.sink                i_in,
    qyt_out_if.source             o_out
);
    t_limits lim;
    t_track  s1;
    logic    s1_valid;
    logic    adv;

    qyt_limits #(
        .COUNT_SCALE   (COUNT_SCALE),
        .COUNT_DIVISOR (COUNT_DIVISOR)
    ) u_limits (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_lim      (lim)
    );

    qyt_tracker #(
        .COUNT_SCALE (COUNT_SCALE)
    ) u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lim      (lim),
        .i_valid    (i_in.valid),
        .i_mode     (i_in.mode),
        .i_phases   (i_in.phases),
        .o_ready    (i_in.ready),
        .i_adv      (adv),
        .o_s1_valid (s1_valid),
        .o_s1       (s1)
    );

    qyt_angle #(
        .COUNT_SCALE   (COUNT_SCALE),
        .COUNT_DIVISOR (COUNT_DIVISOR)
    ) u_angle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_adv      (adv),
        .o_out      (o_out)
    );

endmodule

/* hdl/qyt_checker.sv */
// Port-level checks of the yaw tracker and their bind to the top level.
module qyt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [9:0]  i_out_yaw,
    input logic [10:0] i_out_slot,
    input logic        i_out_found,
    input logic        i_out_wrap
);
    logic       in_acc;
    logic       out_acc;
    logic [1:0] r_pending;
    logic       r_seen;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Track items in flight and whether a found flag was already delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_seen    <= 1'b0;
        end else begin
            if (in_acc && !out_acc) begin
                r_pending <= r_pending + 2'd1;
            end else if (!in_acc && out_acc) begin
                r_pending <= r_pending - 2'd1;
            end
            if (out_acc && i_out_found) begin
                r_seen <= 1'b1;
            end
        end
    end

    // No result without an item in flight, no more than three in flight
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pending != 2'd0))
        else $error("result without a pending item");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !out_acc) |-> (r_pending != 2'd3))
        else $error("more items in flight than pipeline stages");

    // Found flag stays set once delivered
    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_seen) |-> i_out_found)
        else $error("reference found flag cleared");

    // Input held off while limits settle
    a_settle: assert property (@(posedge i_clk)
        (!i_rst_n || i_cfg_we) |=> !i_in_ready)
        else $error("input ready before limit datapath settled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_yaw)
            && $stable(i_out_slot) && $stable(i_out_found) && $stable(i_out_wrap)))
        else $error("stalled result changed");

endmodule

bind quadrature_yaw_tracker_top qyt_checker u_qyt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_yaw   (o_out.yaw_degrees),
    .i_out_slot  (o_out.slot_total),
    .i_out_found (o_out.reference_found),
    .i_out_wrap  (o_out.wrapped)
);

/* dv/quadrature_yaw_tracker_top_test.sv */
// Self-checking testbench for the quadrature yaw tracker: directed table, then random phase runs.
module quadrature_yaw_tracker_top_test;
    import qyt_pkg::*;

    // Angle conversion constants, a zero value counts as one
    localparam int TRACK_SCALE = (SCALE_DEF == 0) ? 1 : SCALE_DEF;
    localparam int TRACK_DIV   = (DIVISOR_DEF == 0) ? 1 : DIVISOR_DEF;
    // Longest correct quiet stretch is a long gap plus a long stall plus the settle
    // after a limit write; allow many times that.
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 75;
    localparam int NUM_PHASES  = 6;

    typedef struct packed {
        logic signed [DEG_W-1:0] yaw;
        logic signed [CNT_W-1:0] slots;
        logic                    found;
        logic                    wrap;
    } t_yaw_result;

    typedef struct packed {
        logic                    lim_row;
        logic                    mode;
        logic [1:0]              ph;
        logic [UP_W-1:0]         up;
        logic signed [DEG_W-1:0] lo;
        logic                    known;
        t_yaw_result             want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    qyt_in_if  in_if();
    qyt_out_if out_if();

    quadrature_yaw_tracker_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Tracker state mirrored on the testbench side
    logic [UP_W-1:0]         lim_up;
    logic signed [DEG_W-1:0] lim_lo;
    logic [1:0]              ph_last;
    logic signed [CNT_W-1:0] slots_q;
    logic                    found_q;

    t_yaw_result yaw_pending[$];
    t_stim_row   stim_rows[$];

    logic calm;
    int   mismatches;
    int   fails;
    int   items_sent;
    int   refs_sent;
    int   results_seen;
    int   wraps_seen;
    int   quiet_cycles;
    int   rdy_hold;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Advance the mirrored state by one item and return the result it causes
    function automatic t_yaw_result track_yaw(input logic mode, input logic [1:0] now);
        logic [3:0]  code;
        int          cnt;
        int          ang;
        int          up_i;
        int          lo_i;
        int          back;
        t_yaw_result r;
        up_i   = lim_up;
        lo_i   = lim_lo;
        ang    = 0;
        r.wrap = 1'b0;
        if (mode == MODE_REF) begin
            slots_q = '0;
            found_q = 1'b1;
        end else begin
            code = {ph_last, now};
            cnt  = slots_q;
            case (code)
                QC_FWD_00_01, QC_FWD_01_11, QC_FWD_11_10, QC_FWD_10_00: cnt = cnt + 1;
                QC_REV_00_10, QC_REV_01_00, QC_REV_11_01, QC_REV_10_11: cnt = cnt - 1;
                default: ;
            endcase
            ph_last = now;
            slots_q = cnt[CNT_W-1:0];
            cnt     = slots_q;
            ang     = (cnt * TRACK_SCALE) / TRACK_DIV;
            // Upper limit is tested first and wins
            if (ang >= up_i) begin
                ang     = lo_i;
                back    = (lo_i * TRACK_DIV) / TRACK_SCALE;
                slots_q = back[CNT_W-1:0];
                r.wrap  = 1'b1;
            end else if (ang <= lo_i) begin
                ang     = up_i;
                back    = (up_i * TRACK_DIV) / TRACK_SCALE;
                slots_q = back[CNT_W-1:0];
                r.wrap  = 1'b1;
            end
        end
        r.yaw   = ang[DEG_W-1:0];
        r.slots = slots_q;
        r.found = found_q;
        return r;
    endfunction

    // Gap length: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Table builders
    task automatic add_item(input logic mode, input logic [1:0] ph);
        t_stim_row row;
        row      = '0;
        row.mode = mode;
        row.ph   = ph;
        stim_rows.push_back(row);
    endtask

    task automatic add_known(input logic mode, input logic [1:0] ph, input int yaw,
                             input int slots, input logic found, input logic wrap);
        t_stim_row row;
        row            = '0;
        row.mode       = mode;
        row.ph         = ph;
        row.known      = 1'b1;
        row.want.yaw   = yaw[DEG_W-1:0];
        row.want.slots = slots[CNT_W-1:0];
        row.want.found = found;
        row.want.wrap  = wrap;
        stim_rows.push_back(row);
    endtask

    task automatic add_limits(input int up, input int lo);
        t_stim_row row;
        row         = '0;
        row.lim_row = 1'b1;
        row.up      = up[UP_W-1:0];
        row.lo      = lo[DEG_W-1:0];
        stim_rows.push_back(row);
    endtask

    // Drive one input item from a falling edge and hold it until the transfer
    task automatic send_item(input logic mode, input logic [1:0] ph, input logic known,
                             input t_yaw_result want);
        int          gap;
        t_yaw_result pred;
        gap = idle_len();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.mode   <= mode;
        in_if.phases <= ph;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pred = track_yaw(mode, ph);
        yaw_pending.push_back(known ? want : pred);
        items_sent++;
        if (mode == MODE_REF) refs_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every expected result is out, plus the pipeline depth
    task automatic settle_pipe();
        in_if.valid <= 1'b0;
        while (yaw_pending.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Write both limit registers while the block is idle
    task automatic set_limits(input logic [UP_W-1:0] up, input logic signed [DEG_W-1:0] lo);
        settle_pipe();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_UPPER;
        i_cfg_data <= {1'b0, up};
        @(negedge i_clk);
        i_cfg_idx  <= REG_LOWER;
        i_cfg_data <= lo;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_up = up;
        lim_lo = lo;
    endtask

    // Result side stalls
    always @(negedge i_clk) begin
        if (rdy_hold > 0) begin
            out_if.ready <= 1'b0;
            rdy_hold = rdy_hold - 1;
        end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 99) < 30) rdy_hold = idle_len();
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_yaw_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (out_if.wrapped) wraps_seen++;
            if (yaw_pending.size() == 0) begin
                fails++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: yaw %0d count %0d found %0b wrapped %0b",
                             out_if.yaw_degrees, out_if.slot_total,
                             out_if.reference_found, out_if.wrapped);
            end else begin
                want = yaw_pending.pop_front();
                if (out_if.yaw_degrees !== want.yaw || out_if.slot_total !== want.slots ||
                    out_if.reference_found !== want.found || out_if.wrapped !== want.wrap) begin
                    fails++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected yaw %0d count %0d found %0b ",
                                  "wrapped %0b, got yaw %0d count %0d found %0b wrapped %0b"},
                                 want.yaw, want.slots, want.found, want.wrap,
                                 out_if.yaw_degrees, out_if.slot_total,
                                 out_if.reference_found, out_if.wrapped);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_stim_row   row;
        t_yaw_result none;
        logic [1:0]  pos;
        logic [1:0]  ph;
        int          run_left;
        int          dir;
        int          r;
        logic [UP_W-1:0]         up;
        logic signed [DEG_W-1:0] lo;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_UPPER;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.mode   = MODE_PHASE;
        in_if.phases = 2'b00;
        out_if.ready = 1'b0;
        rdy_hold     = 0;
        calm         = 1'b0;
        mismatches   = 0;
        fails        = 0;
        items_sent   = 0;
        refs_sent    = 0;
        results_seen = 0;
        wraps_seen   = 0;
        quiet_cycles = 0;
        none         = '0;
        lim_up       = UPPER_RST;
        lim_lo       = LOWER_RST;
        ph_last      = 2'b00;
        slots_q      = '0;
        found_q      = 1'b0;

        // Directed table: every transition code, reference pulses, limit extremes
        add_known(MODE_PHASE, 2'b00, 0, 0, 1'b0, 1'b0);   // unchanged after reset
        add_item(MODE_PHASE, 2'b01);
        add_item(MODE_PHASE, 2'b11);
        add_item(MODE_PHASE, 2'b10);
        add_item(MODE_PHASE, 2'b00);
        add_item(MODE_PHASE, 2'b10);
        add_item(MODE_PHASE, 2'b11);
        add_item(MODE_PHASE, 2'b01);
        add_item(MODE_PHASE, 2'b00);
        add_item(MODE_PHASE, 2'b11);                      // skipped state
        add_item(MODE_PHASE, 2'b00);                      // skipped state
        add_item(MODE_PHASE, 2'b01);
        add_item(MODE_PHASE, 2'b10);                      // skipped state
        add_item(MODE_PHASE, 2'b01);                      // skipped state
        add_item(MODE_PHASE, 2'b01);                      // unchanged
        add_known(MODE_REF, 2'b11, 0, 0, 1'b1, 1'b0);     // reference pulse keeps phases
        add_item(MODE_PHASE, 2'b11);
        add_item(MODE_PHASE, 2'b11);
        add_item(MODE_PHASE, 2'b10);
        add_item(MODE_PHASE, 2'b10);
        add_limits(0, 0);                                 // upper limit hit, wraps to lower
        add_known(MODE_PHASE, 2'b10, 0, 0, 1'b1, 1'b1);
        add_limits(0, -360);
        add_known(MODE_PHASE, 2'b10, -360, -448, 1'b1, 1'b1);
        add_item(MODE_PHASE, 2'b11);                      // lower limit wraps to upper
        add_limits(359, 0);
        add_known(MODE_PHASE, 2'b11, 359, 446, 1'b1, 1'b1);
        add_item(MODE_PHASE, 2'b10);                      // reaches upper extreme
        add_known(MODE_REF, 2'b00, 0, 0, 1'b1, 1'b0);

        // Hold reset, release on a falling edge
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            if (row.lim_row)
                set_limits(row.up, row.lo);
            else
                send_item(row.mode, row.ph, row.known, row.want);
        end

        // Random phases: mostly coherent rotation runs, some noise and pulses
        pos      = {ph_last[1], ph_last[1] ^ ph_last[0]};
        run_left = 0;
        dir      = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin up = UPPER_RST; lo = LOWER_RST; end
                1: begin up = 9'd6; lo = -10'sd6; end
                2: begin up = 9'd359; lo = -10'sd360; end
                3: begin
                    up = 9'($urandom_range(1, 40));
                    lo = -$signed({1'b0, 9'($urandom_range(1, 40))});
                end
                4: begin up = 9'd359; lo = '0; end
                default: begin
                    up = 9'($urandom_range(0, 359));
                    lo = -$signed({1'b0, 9'($urandom_range(0, 360))});
                end
            endcase
            set_limits(up, lo);
            calm = (p == 1 || p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // In one limit setting the sender waits out every pending result mid-run
                if (p == 3 && n == PHASE_ITEMS / 2) settle_pipe();
                if (run_left == 0) begin
                    r        = $urandom_range(0, 99);
                    dir      = (r < 40) ? 0 : (r < 80) ? 1 : 2;
                    run_left = $urandom_range(4, 60);
                end
                run_left--;
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    send_item(MODE_REF, 2'($urandom_range(0, 3)), 1'b0, none);
                end else begin
                    if (dir == 2) begin
                        ph  = 2'($urandom_range(0, 3));
                        pos = {ph[1], ph[1] ^ ph[0]};
                    end else if (r < 6) begin
                        pos = pos + 2'd2;                 // skipped state
                    end else if (r < 9) begin
                        pos = pos;                        // hold position
                    end else if (dir == 0) begin
                        pos = pos + 2'd1;
                    end else begin
                        pos = pos - 2'd1;
                    end
                    ph = {pos[1], pos[1] ^ pos[0]};
                    send_item(MODE_PHASE, ph, 1'b0, none);
                end
            end
        end

        // Drain and let the pipeline run empty
        calm = 1'b0;
        settle_pipe();
        repeat (8) @(posedge i_clk);
        if (yaw_pending.size() != 0) begin
            fails++;
            $display("%0d expected results never arrived", yaw_pending.size());
        end

        $display("Covered %0d inputs (%0d reference pulses) across %0d limit settings",
                 items_sent, refs_sent, NUM_PHASES + 3);
        $display("Checked %0d results, %0d wrapped at a limit, %0d mismatches",
                 results_seen, wraps_seen, mismatches);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
